FILE: design/psg_pkg.sv
// psg_pkg: shared types and constants of the pulse/saw sound generator
// no dependencies; used by the channel interfaces, the top level and the checker

package psg_pkg;

  // word kinds on the command channel
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  // payload widths
  localparam int AddrW  = 16;
  localparam int DataW  = 8;
  localparam int PulseW = 12;
  localparam int SawW   = 13;
  localparam int MixW   = 14;

  typedef logic [PulseW-1:0] pulse_level_t;
  typedef logic [SawW-1:0]   saw_level_t;
  typedef logic [MixW-1:0]   mix_level_t;

  // register decode
  localparam logic [AddrW-1:0] AddrMask  = 16'hF003;
  localparam logic [3:0]       AreaPulse1 = 4'h9;
  localparam logic [3:0]       AreaPulse2 = 4'hA;
  localparam logic [3:0]       AreaSaw    = 4'hB;
  localparam logic [1:0]       LowUnused  = 2'd3;

  // sawtooth clears its accumulator when the step count reaches this
  localparam logic [2:0]       SawStepLast = 3'd7;

endpackage

FILE: design/psg_cmd_if.sv
// psg_cmd_if: command channel (register writes and clock ticks)
// depends on psg_pkg

interface psg_cmd_if import psg_pkg::*;;
  logic             valid;
  logic             ready;
  op_t              op;
  logic [AddrW-1:0] address;
  logic [DataW-1:0] data;

  modport source (output valid, op, address, data, input ready);
  modport sink   (input valid, op, address, data, output ready);
endinterface

FILE: design/psg_sound_if.sv
// psg_sound_if: result channel carrying the channel levels and their sum
// depends on psg_pkg

interface psg_sound_if import psg_pkg::*;;
  logic         valid;
  logic         ready;
  pulse_level_t pulse1_level;
  pulse_level_t pulse2_level;
  saw_level_t   saw_level;
  mix_level_t   mixed_level;

  modport source (output valid, pulse1_level, pulse2_level, saw_level, mixed_level,
                  input ready);
  modport sink   (input valid, pulse1_level, pulse2_level, saw_level, mixed_level,
                  output ready);
endinterface

FILE: design/pulse_saw_sound_generator_unit.sv
// pulse_saw_sound_generator_unit: two pulse channels and one sawtooth channel
// depends on psg_pkg, psg_cmd_if, psg_sound_if

// Each command word is either a register write or one CPU clock tick. A tick
// produces exactly one sound word on the next cycle (levels of both pulse
// channels, the sawtooth level and their sum, sampled before the timers
// advance); a write produces none and affects only later ticks. One command
// word is taken every cycle; the single output register holds a finished word
// while the next command is taken, so the command side stalls only when that
// register is full and the sink is not ready. The address-swap bit is written
// through cfg_wr_en/cfg_wr_data by the user while the block is idle; not enforced.

module pulse_saw_sound_generator_unit import psg_pkg::*; #(
  parameter int PULSE_CHANNELS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  psg_cmd_if.sink     cmd,
  psg_sound_if.source sound
);

  // architectural state
  logic             swap;
  logic [DataW-1:0] pulse_regs [6];
  logic [DataW-1:0] saw_regs [3];
  logic [12:0]      pulse_timer [2];
  logic [3:0]       duty_step [2];
  logic [13:0]      saw_timer;
  logic [8:0]       saw_accum;
  logic [2:0]       saw_step;

  // output register
  logic         out_valid;
  pulse_level_t out_p1;
  pulse_level_t out_p2;
  saw_level_t   out_saw;
  mix_level_t   out_mix;

  logic             accept;
  logic             is_tick;
  logic             is_write;
  logic [AddrW-1:0] addr_sw;
  logic [AddrW-1:0] addr_m;
  logic [1:0]       low;
  logic [3:0]       area;
  pulse_level_t     pulse_level [2];
  saw_level_t       saw_level;
  mix_level_t       mix_level;

  // handshake
  assign cmd.ready = !out_valid || sound.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign is_tick   = accept && (cmd.op == OP_TICK);
  assign is_write  = accept && (cmd.op == OP_WRITE);

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      swap <= 1'b0;
    end else if (cfg_wr_en) begin
      swap <= cfg_wr_data;
    end
  end

  // address decode with optional swap of the two low lines
  assign addr_sw = swap ? {cmd.address[15:2], cmd.address[0], cmd.address[1]} : cmd.address;
  assign addr_m  = addr_sw & AddrMask;
  assign low     = addr_m[1:0];
  assign area    = addr_m[15:12];

  // sound register file
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) pulse_regs[i] <= '0;
      for (int i = 0; i < 3; i++) saw_regs[i] <= '0;
    end else if (is_write && (low != LowUnused)) begin
      case (area)
        AreaPulse1: pulse_regs[{1'b0, low}] <= cmd.data;
        AreaPulse2: pulse_regs[3'd3 + {1'b0, low}] <= cmd.data;
        AreaSaw:    saw_regs[low] <= cmd.data;
        default:    ;
      endcase
    end
  end

  // pulse channels
  for (genvar ch = 0; ch < 2; ch++) begin : g_pulse
    localparam bit Present = (ch < PULSE_CHANNELS);
    logic [3:0]  vol;
    logic [2:0]  thresh;
    logic        digital;
    logic        active;
    logic [11:0] period;
    logic        run;
    logic [11:0] vol_x192;

    assign vol     = pulse_regs[3*ch][3:0];
    assign thresh  = pulse_regs[3*ch][6:4];
    assign digital = pulse_regs[3*ch][7];
    assign active  = Present && pulse_regs[3*ch+2][7];
    assign period  = {pulse_regs[3*ch+2][3:0], pulse_regs[3*ch+1]};
    assign run     = is_tick && active && !digital;

    // volume * 192 as two shifted copies
    assign vol_x192 = {1'b0, vol, 7'b0} + {2'b0, vol, 6'b0};

    assign pulse_level[ch] = (active && (digital || (duty_step[ch] > {1'b0, thresh})))
                             ? vol_x192 : '0;

    // timer and duty step
    always_ff @(posedge clk) begin
      if (rst) begin
        pulse_timer[ch] <= '0;
        duty_step[ch]   <= '0;
      end else if (run) begin
        if (pulse_timer[ch] <= 13'd1) begin
          pulse_timer[ch] <= {1'b0, period} + 13'd1;
          duty_step[ch]   <= duty_step[ch] + 4'd1;
        end else begin
          pulse_timer[ch] <= pulse_timer[ch] - 13'd1;
        end
      end
    end
  end

  // sawtooth channel
  logic        saw_en;
  logic [11:0] saw_period;
  logic [12:0] saw_period_p1;
  logic [4:0]  saw_top;
  logic [2:0]  saw_step_inc;

  assign saw_en        = saw_regs[2][7];
  assign saw_period    = {saw_regs[2][3:0], saw_regs[1]};
  assign saw_period_p1 = {1'b0, saw_period} + 13'd1;
  assign saw_top       = saw_accum[7:3];
  assign saw_step_inc  = saw_step + 3'd1;
  assign saw_level     = saw_en ? ({1'b0, saw_top, 7'b0} + {2'b0, saw_top, 6'b0}) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      saw_timer <= '0;
      saw_accum <= '0;
      saw_step  <= '0;
    end else if (is_tick && saw_en) begin
      if (saw_timer <= 14'd1) begin
        saw_timer <= {saw_period_p1, 1'b0};
        if (saw_step_inc == SawStepLast) begin
          saw_step  <= '0;
          saw_accum <= '0;
        end else begin
          saw_step  <= saw_step_inc;
          saw_accum <= saw_accum + {3'b0, saw_regs[0][5:0]};
        end
      end else begin
        saw_timer <= saw_timer - 14'd1;
      end
    end
  end

  // mixer
  assign mix_level = {2'b0, pulse_level[0]} + {2'b0, pulse_level[1]} + {1'b0, saw_level};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (is_tick) begin
      out_valid <= 1'b1;
    end else if (sound.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_tick) begin
      out_p1  <= pulse_level[0];
      out_p2  <= pulse_level[1];
      out_saw <= saw_level;
      out_mix <= mix_level;
    end
  end

  assign sound.valid        = out_valid;
  assign sound.pulse1_level = out_p1;
  assign sound.pulse2_level = out_p2;
  assign sound.saw_level    = out_saw;
  assign sound.mixed_level  = out_mix;

endmodule

FILE: design/psg_checker.sv
// psg_checker: port-level checks of the sound generator over time
// depends on psg_pkg; bound to pulse_saw_sound_generator_unit

module psg_checker import psg_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         cmd_valid,
  input logic         cmd_ready,
  input op_t          cmd_op,
  input logic         sound_valid,
  input logic         sound_ready,
  input pulse_level_t pulse1_level,
  input pulse_level_t pulse2_level,
  input saw_level_t   saw_level,
  input mix_level_t   mixed_level
);

  // output register empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !sound_valid)
    else $error("sound word valid after reset");

  // stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    sound_valid && !sound_ready |=> sound_valid && $stable(mixed_level))
    else $error("stalled sound word changed");

  // mix is the sum of the channel levels
  a_mix_sum: assert property (@(posedge clk) disable iff (rst)
    sound_valid |-> mixed_level ==
      ({2'b0, pulse1_level} + {2'b0, pulse2_level} + {1'b0, saw_level}))
    else $error("mixed level is not the channel sum");

  // every accepted tick yields a word next cycle
  a_tick_word: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd_op == OP_TICK) |=> sound_valid)
    else $error("tick produced no sound word");

  // a write into a free output register yields nothing
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd_op == OP_WRITE) && (!sound_valid || sound_ready)
      |=> !sound_valid)
    else $error("register write produced a sound word");

endmodule

bind pulse_saw_sound_generator_unit psg_checker u_psg_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .cmd_op       (cmd.op),
  .sound_valid  (sound.valid),
  .sound_ready  (sound.ready),
  .pulse1_level (sound.pulse1_level),
  .pulse2_level (sound.pulse2_level),
  .saw_level    (sound.saw_level),
  .mixed_level  (sound.mixed_level)
);
